FILE: hdl/brl_pkg.sv
// Shared types and constants for the blocked run length tracker.
// Used by the front end, the queue and the back end; depends on nothing.
`timescale 1ns / 1ps
package brl_pkg;

  localparam int POS_W  = 11;
  localparam int LEN_W  = 17;
  localparam int STAT_W = 3;
  localparam int WORD_W = 64;
  localparam int BW     = 6;

  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_RANGE   = 3'd1;
  localparam logic [STAT_W-1:0] ST_BLOCKED = 3'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL    = 3'd4;

  typedef enum logic [1:0] {
    ACT_BLOCK   = 2'd0,
    ACT_RESTORE = 2'd1,
    ACT_QUERY   = 2'd2,
    ACT_UNUSED  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    OP_BLOCK   = 2'd0,
    OP_RESTORE = 2'd1,
    OP_QUERY   = 2'd2,
    OP_REPORT  = 2'd3
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  pos;
    logic [LEN_W-1:0]  len;
  } item_t;

endpackage

FILE: hdl/brl_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Self-contained; used for the bitmap words and the undo stack.
`timescale 1ns / 1ps
module brl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: hdl/brl_queue.sv
// Two-entry queue of classified items between the front end and the back end.
// Depends on brl_pkg for the item type.
`timescale 1ns / 1ps
module brl_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  brl_pkg::item_t wr_item,
  input  logic          pop,
  output brl_pkg::item_t rd_item,
  output logic          full,
  output logic          empty
);
  import brl_pkg::*;

  item_t      ent_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign rd_item = ent_r[rp_r];
  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      ent_r[wp_r] <= wr_item;
    end
  end
endmodule

FILE: hdl/brl_front.sv
// Front end: configuration register, input acceptance and item classification.
// Depends on brl_pkg; feeds brl_queue.
`timescale 1ns / 1ps
module brl_front #(
  parameter int MAX_POSITIONS = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [2:0]                  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready,
  input  logic                        start,
  input  logic [1:0]                  in_action,
  input  logic [brl_pkg::POS_W-1:0]   in_position,
  input  logic                        q_full,
  input  logic                        clearing,
  output logic                        busy,
  output logic                        push,
  output brl_pkg::item_t              item
);
  import brl_pkg::*;

  logic [POS_W-1:0] row_length_r, row_length_nxt;
  logic [LEN_W-1:0] len, rl17, pos17, max17;
  logic             in_range;
  action_t          act;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 3'd0) ? {21'd0, row_length_r} : 32'd0;
  assign busy       = q_full | clearing;
  assign push       = start & ~busy;

  always_comb begin
    row_length_nxt = row_length_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 3'd0) begin
      row_length_nxt = cfg_pwdata[POS_W-1:0];
    end
  end

  always_comb begin
    rl17  = LEN_W'(row_length_r);
    pos17 = LEN_W'(in_position);
    max17 = LEN_W'(MAX_POSITIONS);
    if (rl17 == '0) begin
      len = LEN_W'(1);
    end else if (rl17 > max17) begin
      len = max17;
    end else begin
      len = rl17;
    end
    in_range    = (pos17 != '0) && (pos17 <= len);
    act         = action_t'(in_action);
    item.pos    = in_position;
    item.len    = len;
    item.status = ST_OK;
    item.op     = OP_REPORT;
    case (act)
      ACT_BLOCK: begin
        if (in_range) begin
          item.op = OP_BLOCK;
        end else begin
          item.status = ST_RANGE;
        end
      end
      ACT_RESTORE: begin
        item.op = OP_RESTORE;
      end
      ACT_QUERY: begin
        if (in_range) begin
          item.op = OP_QUERY;
        end else begin
          item.status = ST_RANGE;
        end
      end
      default: begin
        item.op = OP_REPORT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_length_r <= POS_W'(1024);
    end else begin
      row_length_r <= row_length_nxt;
    end
  end
endmodule

FILE: hdl/brl_back.sv
// Back end: executes items against the bitmap words and the undo stack RAMs.
// Depends on brl_pkg and brl_ram.
`timescale 1ns / 1ps
module brl_back #(
  parameter int MAX_POSITIONS = 1024,
  parameter int STACK_DEPTH   = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  brl_pkg::item_t               q_item,
  input  logic                         q_empty,
  output logic                         pop,
  output logic                         clearing,
  output logic                         out_strobe,
  output logic [brl_pkg::POS_W-1:0]    out_run_length,
  output logic [brl_pkg::POS_W-1:0]    out_restored_position,
  output logic [brl_pkg::STAT_W-1:0]   out_status
);
  import brl_pkg::*;

  localparam int NW      = (MAX_POSITIONS + WORD_W - 1) / WORD_W;
  localparam int WAW     = (NW > 1) ? $clog2(NW) : 1;
  localparam int PIDX_W  = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
  localparam int CW      = $clog2(STACK_DEPTH + 1);
  localparam int SAW     = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  typedef enum logic [6:0] {
    S_CLR    = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_WAIT_S = 7'b0000100,
    S_WAIT_B = 7'b0001000,
    S_LEFT   = 7'b0010000,
    S_RCEN   = 7'b0100000,
    S_RIGHT  = 7'b1000000
  } state_t;

  state_t             state_r, state_nxt;
  item_t              cur_r, cur_nxt;
  logic [PIDX_W-1:0]  idx_r, idx_nxt;
  logic [WAW-1:0]     word_r, word_nxt, clr_r, clr_nxt;
  logic [WORD_W-1:0]  cw_r, cw_nxt;
  logic [LEN_W-1:0]   lo_r, lo_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt, cnt_m1;

  logic               ostb_r, ostb_nxt;
  logic [POS_W-1:0]   orun_r, orun_nxt, orest_r, orest_nxt;
  logic [STAT_W-1:0]  ost_r, ost_nxt;

  logic               bm_we;
  logic [WAW-1:0]     bm_waddr, bm_raddr;
  logic [WORD_W-1:0]  bm_wdata, bm_rdata;
  logic               st_we;
  logic [SAW-1:0]     st_waddr, st_raddr;
  logic [PIDX_W-1:0]  st_wdata, st_rdata;

  logic [LEN_W-1:0]   idx17, q_idx17, st17, base17, basec, rbase, hi, run17, lastw17;
  logic [PIDX_W-1:0]  q_idx;
  logic [BW-1:0]      bitp;
  logic [WAW-1:0]     word_c, rword, lastw;
  logic [BW:0]        fd, fu;
  logic [WORD_W-1:0]  onehot;

  function automatic logic [BW:0] find_down(logic [WORD_W-1:0] v, logic [BW:0] s);
    logic [BW:0] r;
    r = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (v[i] && i < int'(s)) begin
        r = {1'b1, BW'(i)};
      end
    end
    return r;
  endfunction

  function automatic logic [BW:0] find_up(logic [WORD_W-1:0] v, logic [BW-1:0] s,
                                          logic [LEN_W-1:0] base, logic [LEN_W-1:0] len);
    logic [BW:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if ((v[i] || (base + LEN_W'(i)) >= len) && i >= int'(s)) begin
        r = {1'b1, BW'(i)};
      end
    end
    return r;
  endfunction

  brl_ram #(.WIDTH(WORD_W), .DEPTH(NW)) u_bitmap (
    .clk(clk), .we(bm_we), .waddr(bm_waddr), .wdata(bm_wdata),
    .raddr(bm_raddr), .rdata(bm_rdata)
  );

  brl_ram #(.WIDTH(PIDX_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata)
  );

  assign clearing              = (state_r == S_CLR);
  assign out_strobe            = ostb_r;
  assign out_run_length        = orun_r;
  assign out_restored_position = orest_r;
  assign out_status            = ost_r;

  always_comb begin
    q_idx17 = LEN_W'(q_item.pos) - LEN_W'(1);
    q_idx   = q_idx17[PIDX_W-1:0];
    idx17   = LEN_W'(idx_r);
    st17    = LEN_W'(st_rdata);
    bitp    = idx17[BW-1:0];
    word_c  = WAW'(idx17 >> BW);
    base17  = LEN_W'(word_r) << BW;
    basec   = LEN_W'(word_c) << BW;
    lastw17 = (cur_r.len - LEN_W'(1)) >> BW;
    lastw   = WAW'(lastw17);
    onehot  = WORD_W'(1) << bitp;
    fd      = find_down(bm_rdata, (state_r == S_WAIT_B) ? {1'b0, bitp} : (BW+1)'(WORD_W));
    rword   = (state_r == S_RCEN) ? word_c : word_r;
    rbase   = (state_r == S_RCEN) ? basec : base17;
    fu      = find_up((state_r == S_RCEN) ? cw_r : bm_rdata,
                      (state_r == S_RCEN) ? bitp : BW'(0), rbase, cur_r.len);
    hi      = rbase + LEN_W'(fu[BW-1:0]) - LEN_W'(1);
    if (!fu[BW]) begin
      hi = cur_r.len - LEN_W'(1);
    end
    run17   = hi - lo_r + LEN_W'(1);
    cnt_m1  = cnt_r - CW'(1);
  end

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    idx_nxt   = idx_r;
    word_nxt  = word_r;
    clr_nxt   = clr_r;
    cw_nxt    = cw_r;
    lo_nxt    = lo_r;
    cnt_nxt   = cnt_r;
    ostb_nxt  = 1'b0;
    orun_nxt  = '0;
    orest_nxt = '0;
    ost_nxt   = ST_OK;
    pop       = 1'b0;
    bm_we     = 1'b0;
    bm_waddr  = word_r;
    bm_wdata  = '0;
    bm_raddr  = word_r;
    st_we     = 1'b0;
    st_waddr  = cnt_r[SAW-1:0];
    st_wdata  = idx_r;
    st_raddr  = cnt_m1[SAW-1:0];
    case (state_r)
      S_CLR: begin
        bm_we    = 1'b1;
        bm_waddr = clr_r;
        clr_nxt  = clr_r + WAW'(1);
        if (clr_r == WAW'(NW - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!q_empty) begin
          pop     = 1'b1;
          cur_nxt = q_item;
          case (q_item.op)
            OP_REPORT: begin
              ostb_nxt = 1'b1;
              ost_nxt  = q_item.status;
            end
            OP_RESTORE: begin
              if (cnt_r == '0) begin
                ostb_nxt = 1'b1;
                ost_nxt  = ST_EMPTY;
              end else begin
                cnt_nxt   = cnt_m1;
                state_nxt = S_WAIT_S;
              end
            end
            default: begin
              idx_nxt   = q_idx;
              word_nxt  = WAW'(q_idx17 >> BW);
              bm_raddr  = WAW'(q_idx17 >> BW);
              state_nxt = S_WAIT_B;
            end
          endcase
        end
      end
      S_WAIT_S: begin
        idx_nxt   = st_rdata;
        word_nxt  = WAW'(st17 >> BW);
        bm_raddr  = WAW'(st17 >> BW);
        state_nxt = S_WAIT_B;
      end
      S_WAIT_B: begin
        state_nxt = S_IDLE;
        case (cur_r.op)
          OP_BLOCK: begin
            ostb_nxt = 1'b1;
            if (bm_rdata[bitp]) begin
              ost_nxt = ST_BLOCKED;
            end else if (cnt_r == CW'(STACK_DEPTH)) begin
              ost_nxt = ST_FULL;
            end else begin
              bm_we    = 1'b1;
              bm_wdata = bm_rdata | onehot;
              st_we    = 1'b1;
              cnt_nxt  = cnt_r + CW'(1);
            end
          end
          OP_RESTORE: begin
            bm_we     = 1'b1;
            bm_wdata  = bm_rdata & ~onehot;
            ostb_nxt  = 1'b1;
            orest_nxt = POS_W'(idx17 + LEN_W'(1));
          end
          OP_QUERY: begin
            if (bm_rdata[bitp]) begin
              ostb_nxt = 1'b1;
            end else begin
              cw_nxt = bm_rdata;
              if (fd[BW]) begin
                lo_nxt    = base17 + LEN_W'(fd[BW-1:0]) + LEN_W'(1);
                state_nxt = S_RCEN;
              end else if (word_r == '0) begin
                lo_nxt    = '0;
                state_nxt = S_RCEN;
              end else begin
                word_nxt  = word_r - WAW'(1);
                bm_raddr  = word_r - WAW'(1);
                state_nxt = S_LEFT;
              end
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_LEFT: begin
        if (fd[BW]) begin
          lo_nxt    = base17 + LEN_W'(fd[BW-1:0]) + LEN_W'(1);
          state_nxt = S_RCEN;
        end else if (word_r == '0) begin
          lo_nxt    = '0;
          state_nxt = S_RCEN;
        end else begin
          word_nxt = word_r - WAW'(1);
          bm_raddr = word_r - WAW'(1);
        end
      end
      S_RCEN, S_RIGHT: begin
        if (fu[BW] || rword == lastw) begin
          ostb_nxt  = 1'b1;
          orun_nxt  = run17[POS_W-1:0];
          state_nxt = S_IDLE;
        end else begin
          word_nxt  = rword + WAW'(1);
          bm_raddr  = rword + WAW'(1);
          state_nxt = S_RIGHT;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      cnt_r   <= '0;
      ostb_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      cnt_r   <= cnt_nxt;
      ostb_r  <= ostb_nxt;
    end
    cur_r   <= cur_nxt;
    idx_r   <= idx_nxt;
    word_r  <= word_nxt;
    cw_r    <= cw_nxt;
    lo_r    <= lo_nxt;
    orun_r  <= orun_nxt;
    orest_r <= orest_nxt;
    ost_r   <= ost_nxt;
  end
endmodule

FILE: hdl/blocked_run_length_tracker.sv
// Top level of the blocked run length tracker.
// Instantiates brl_front, brl_queue and brl_back; depends on brl_pkg.
//
// Usage: an item (action, position) is accepted at a rising edge with start
// high and busy low. Each item gives exactly one result, shown for one cycle
// with out_strobe high; the receiver cannot stall, so results are never held.
// The row_length register sits at byte address 0 of the APB-style port and
// may be written only while the block is idle.
// Out-of-range and unused items and restores on an empty stack are answered
// straight from the idle state; a block or a query in range reads its bitmap
// word, and a restore first reads the undo stack and then the bitmap word. A
// query of an intact position reads one further 64-bit bitmap word at a time
// while scanning left and right, as the bitmap RAM has a single read port.
// Up to two items wait in the queue between front end and back end; busy
// rises when it is full.
// After reset the bitmap RAM is cleared one word per cycle with busy high;
// row_length resets to 1024 and the undo stack to empty.
`timescale 1ns / 1ps
module blocked_run_length_tracker #(
  parameter int MAX_POSITIONS = 1024,
  parameter int STACK_DEPTH   = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [2:0]                  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_action,
  input  logic [brl_pkg::POS_W-1:0]   in_position,
  output logic                        out_strobe,
  output logic [brl_pkg::POS_W-1:0]   out_run_length,
  output logic [brl_pkg::POS_W-1:0]   out_restored_position,
  output logic [brl_pkg::STAT_W-1:0]  out_status
);
  import brl_pkg::*;

  item_t push_item, head_item;
  logic  push, pop, q_full, q_empty, clearing;

  brl_front #(.MAX_POSITIONS(MAX_POSITIONS)) u_front (
    .clk(clk), .rst_n(rst_n),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready),
    .start(start), .in_action(in_action), .in_position(in_position),
    .q_full(q_full), .clearing(clearing), .busy(busy),
    .push(push), .item(push_item)
  );

  brl_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .wr_item(push_item),
    .pop(pop), .rd_item(head_item), .full(q_full), .empty(q_empty)
  );

  brl_back #(.MAX_POSITIONS(MAX_POSITIONS), .STACK_DEPTH(STACK_DEPTH)) u_back (
    .clk(clk), .rst_n(rst_n), .q_item(head_item), .q_empty(q_empty),
    .pop(pop), .clearing(clearing), .out_strobe(out_strobe),
    .out_run_length(out_run_length), .out_restored_position(out_restored_position),
    .out_status(out_status)
  );
endmodule

FILE: hdl/brl_checker.sv
// Port-level checker for the blocked run length tracker, bound to the top level.
// Depends on brl_pkg for the status codes.
`timescale 1ns / 1ps
module brl_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        busy,
  input logic                        out_strobe,
  input logic [brl_pkg::POS_W-1:0]   out_run_length,
  input logic [brl_pkg::POS_W-1:0]   out_restored_position,
  input logic [brl_pkg::STAT_W-1:0]  out_status
);
  import brl_pkg::*;

  a_clear_after_reset: assert property (@(posedge clk)
    (rst_n && !$past(rst_n)) |-> busy)
    else $error("busy low right after reset");

  a_status_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_status == ST_OK || out_status == ST_RANGE ||
                    out_status == ST_BLOCKED || out_status == ST_EMPTY ||
                    out_status == ST_FULL))
    else $error("undefined status code");

  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status != ST_OK) |->
      (out_run_length == '0 && out_restored_position == '0))
    else $error("error result carries data");

  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_run_length != '0) |-> (out_restored_position == '0))
    else $error("result carries both run length and restored position");
endmodule

bind blocked_run_length_tracker brl_checker u_brl_checker (
  .clk(clk), .rst_n(rst_n), .busy(busy), .out_strobe(out_strobe),
  .out_run_length(out_run_length), .out_restored_position(out_restored_position),
  .out_status(out_status)
);

FILE: sim/testbench.sv
// Testbench for the blocked run length tracker: directed table, then random items.
// Predicts results from its own bitmap and undo stack, or takes them from the table; depends on brl_pkg and the RTL.
`timescale 1ns / 1ps
module testbench;
  import brl_pkg::*;

  localparam int NPOS = 1024;
  localparam int DEPTH = 1024;
  localparam logic [2:0] ADDR_ROW_LENGTH = 3'd0;

  typedef struct packed {
    logic [POS_W-1:0]  run;
    logic [POS_W-1:0]  restored;
    logic [STAT_W-1:0] status;
  } outcome_t;

  typedef struct {
    action_t         act;
    logic [POS_W-1:0] pos;
    bit              typed;
    outcome_t        want;
  } row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;
  logic start = 0;
  logic busy;
  logic [1:0] in_action = '0;
  logic [POS_W-1:0] in_position = '0;
  logic out_strobe;
  logic [POS_W-1:0] out_run_length, out_restored_position;
  logic [STAT_W-1:0] out_status;

  bit blocked[NPOS];
  logic [POS_W-1:0] undo[DEPTH];
  int depth_used;
  int row_len;
  outcome_t pending[$];
  int errors = 0;
  bit quiet = 0;

  blocked_run_length_tracker dut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  initial begin
    #50ms;
    $display("Verification failed");
    $finish;
  end

  function automatic int used_len();
    if (row_len < 1) return 1;
    if (row_len > NPOS) return NPOS;
    return row_len;
  endfunction

  function automatic outcome_t predict_outcome(action_t act, logic [POS_W-1:0] pos);
    outcome_t r;
    int len, lo, hi;
    bit ok;
    r = '0;
    len = used_len();
    ok = pos >= 1 && pos <= len;
    case (act)
      ACT_BLOCK: begin
        if (!ok) r.status = ST_RANGE;
        else if (blocked[pos-1]) r.status = ST_BLOCKED;
        else if (depth_used >= DEPTH) r.status = ST_FULL;
        else begin
          blocked[pos-1] = 1;
          undo[depth_used] = pos;
          depth_used++;
        end
      end
      ACT_RESTORE: begin
        if (depth_used == 0) r.status = ST_EMPTY;
        else begin
          depth_used--;
          blocked[undo[depth_used]-1] = 0;
          r.restored = undo[depth_used];
        end
      end
      ACT_QUERY: begin
        if (!ok) r.status = ST_RANGE;
        else if (!blocked[pos-1]) begin
          lo = pos;
          hi = pos;
          while (lo > 1 && !blocked[lo-2]) lo--;
          while (hi < len && !blocked[hi]) hi++;
          r.run = POS_W'(hi - lo + 1);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int exp);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp, $time);
    errors++;
  endtask

  always @(posedge clk) begin
    outcome_t e;
    if (rst_n && out_strobe) begin
      if (pending.size() == 0) report_mismatch("unexpected result", out_status, -1);
      else begin
        e = pending.pop_front();
        if (out_run_length !== e.run) report_mismatch("run_length", out_run_length, e.run);
        if (out_restored_position !== e.restored)
          report_mismatch("restored_position", out_restored_position, e.restored);
        if (out_status !== e.status) report_mismatch("status", out_status, e.status);
      end
    end
  end

  task automatic send_item(action_t act, logic [POS_W-1:0] pos, bit typed = 1'b0,
                           outcome_t want = '0);
    int gap;
    outcome_t e;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start <= 1;
    in_action <= act;
    in_position <= pos;
    @(posedge clk);
    while (busy) @(posedge clk);
    e = predict_outcome(act, pos);
    if (typed) e = want;
    pending = {pending, e};
  endtask

  task automatic settle();
    start <= 0;
    while (pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_row_length(int value);
    settle();
    cfg_psel <= 1;
    cfg_pwrite <= 1;
    cfg_paddr <= ADDR_ROW_LENGTH;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 0;
    cfg_penable <= 0;
    cfg_pwrite <= 0;
    row_len = value & 11'h7ff;
  endtask

  function automatic logic [POS_W-1:0] pick_pos();
    int len;
    len = used_len();
    case ($urandom_range(0, 19))
      0: return POS_W'(0);
      1: return POS_W'($urandom_range(0, 2047));
      2: return POS_W'(len);
      3: return POS_W'(1);
      default: return POS_W'($urandom_range(1, len));
    endcase
  endfunction

  task automatic random_phase(int count, int len_value);
    int k, act;
    write_row_length(len_value);
    for (k = 0; k < count; k++) begin
      act = $urandom_range(0, 19);
      if (act < 8) send_item(ACT_BLOCK, pick_pos());
      else if (act < 12) send_item(ACT_RESTORE, POS_W'($urandom_range(0, 2047)));
      else if (act < 19) send_item(ACT_QUERY, pick_pos());
      else send_item(ACT_UNUSED, POS_W'($urandom_range(0, 2047)));
    end
  endtask

  initial begin
    row_t rows[$];
    int n;
    row_len = 1024;
    depth_used = 0;
    rows = '{
      '{ACT_QUERY, 11'd1, 1, '{11'd1024, 11'd0, ST_OK}},
      '{ACT_QUERY, 11'd1024, 1, '{11'd1024, 11'd0, ST_OK}},
      '{ACT_QUERY, 11'd0, 1, '{11'd0, 11'd0, ST_RANGE}},
      '{ACT_QUERY, 11'd1025, 1, '{11'd0, 11'd0, ST_RANGE}},
      '{ACT_QUERY, 11'd2047, 1, '{11'd0, 11'd0, ST_RANGE}},
      '{ACT_RESTORE, 11'd5, 1, '{11'd0, 11'd0, ST_EMPTY}},
      '{ACT_BLOCK, 11'd0, 1, '{11'd0, 11'd0, ST_RANGE}},
      '{ACT_BLOCK, 11'd2047, 1, '{11'd0, 11'd0, ST_RANGE}},
      '{ACT_BLOCK, 11'd512, 1, '{11'd0, 11'd0, ST_OK}},
      '{ACT_BLOCK, 11'd512, 1, '{11'd0, 11'd0, ST_BLOCKED}},
      '{ACT_QUERY, 11'd512, 1, '{11'd0, 11'd0, ST_OK}},
      '{ACT_QUERY, 11'd1, 0, '0},
      '{ACT_QUERY, 11'd1024, 0, '0},
      '{ACT_BLOCK, 11'd1, 0, '0},
      '{ACT_BLOCK, 11'd1024, 0, '0},
      '{ACT_QUERY, 11'd2, 0, '0},
      '{ACT_UNUSED, 11'd2047, 1, '{11'd0, 11'd0, ST_OK}},
      '{ACT_RESTORE, 11'd0, 1, '{11'd0, 11'd1024, ST_OK}},
      '{ACT_RESTORE, 11'd0, 1, '{11'd0, 11'd1, ST_OK}},
      '{ACT_RESTORE, 11'd0, 1, '{11'd0, 11'd512, ST_OK}},
      '{ACT_QUERY, 11'd700, 1, '{11'd1024, 11'd0, ST_OK}}
    };
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    foreach (rows[i]) begin
      send_item(rows[i].act, rows[i].pos, rows[i].typed, rows[i].want);
    end
    random_phase(20, 0);
    random_phase(50, 2047);
    random_phase(25, 3);
    random_phase(40, 64);
    // A shortened row leaves blocked entries beyond its end to be restored.
    random_phase(30, 1024);
    write_row_length(1024);
    for (n = 0; n < DEPTH; n++) send_item(ACT_BLOCK, POS_W'(n + 1));
    send_item(ACT_RESTORE, 11'd0);
    send_item(ACT_BLOCK, 11'd1024);
    send_item(ACT_BLOCK, 11'd1024);
    write_row_length(1023);
    send_item(ACT_BLOCK, 11'd5);
    random_phase(20, 1);
    random_phase(25, 700);
    quiet = 1;
    random_phase(40, 100);
    settle();
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
